/* rtl/core/smfp_pkg.sv */
// Package with the types and constants shared by the MIDI file parser modules.
package smfp_pkg;

	typedef enum logic [3:0] {
		PH_HDR    = 4'd0,
		PH_TRK    = 4'd1,
		PH_DELTA  = 4'd2,
		PH_STATUS = 4'd3,
		PH_DATA1  = 4'd4,
		PH_DATA2  = 4'd5,
		PH_SYXLEN = 4'd6,
		PH_MTYPE  = 4'd7,
		PH_MLEN   = 4'd8,
		PH_FIXED  = 4'd9,
		PH_RUN    = 4'd10
	} phase_t;

	localparam logic [3:0] K_HEADER     = 4'd0;
	localparam logic [3:0] K_TRACK      = 4'd1;
	localparam logic [3:0] K_CHANNEL    = 4'd2;
	localparam logic [3:0] K_SYSEX      = 4'd3;
	localparam logic [3:0] K_FIXED_META = 4'd4;
	localparam logic [3:0] K_RUN_META   = 4'd5;
	localparam logic [3:0] K_PAYLOAD    = 4'd6;
	localparam logic [3:0] K_END_TRACK  = 4'd7;
	localparam logic [3:0] K_BAD_HEADER = 4'd8;
	localparam logic [3:0] K_BAD_TRACK  = 4'd9;
	localparam logic [3:0] K_BAD_STATUS = 4'd10;

	localparam logic [7:0] META_SEQ    = 8'h00;
	localparam logic [7:0] META_CHAN   = 8'h20;
	localparam logic [7:0] META_EOT    = 8'h2F;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] META_SMPTE  = 8'h54;
	localparam logic [7:0] META_TSIG   = 8'h58;
	localparam logic [7:0] META_KSIG   = 8'h59;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_ESCAPE   = 8'hF7;
	localparam logic [7:0] ST_META     = 8'hFF;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] track_number;
		logic [31:0] timestamp;
		logic [7:0]  status_byte;
		logic [7:0]  meta_type;
		logic [15:0] data_a;
		logic [15:0] data_b;
		logic [39:0] packed_payload;
		logic [31:0] payload_length;
		logic        last_in_run;
		logic        file_done;
	} rec_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] len_acc;
		logic [31:0] tick;
		logic [7:0]  run_st;
		logic [7:0]  cur_st;
		logic [7:0]  meta_t;
		logic [31:0] remain;
		logic [39:0] shift;
		logic [3:0]  idx;
		logic [15:0] trk_idx;
		logic [15:0] trk_tot;
		logic [15:0] fmt;
		logic        halted;
	} pstate_t;

	function automatic logic [7:0] hdr_id(input logic [1:0] i);
		case (i)
			2'd0:    hdr_id = 8'h4D;
			2'd1:    hdr_id = 8'h54;
			2'd2:    hdr_id = 8'h68;
			default: hdr_id = 8'h64;
		endcase
	endfunction

	function automatic logic [7:0] trk_id(input logic [1:0] i);
		case (i)
			2'd0:    trk_id = 8'h4D;
			2'd1:    trk_id = 8'h54;
			2'd2:    trk_id = 8'h72;
			default: trk_id = 8'h6B;
		endcase
	endfunction

	function automatic logic is_fixed_meta(input logic [7:0] t);
		is_fixed_meta = (t == META_SEQ) || (t == META_CHAN) || (t == META_TEMPO) ||
			(t == META_SMPTE) || (t == META_TSIG) || (t == META_KSIG);
	endfunction

endpackage

/* rtl/core/smfp_step.sv */
// Next-state and record logic for one byte of the MIDI file parser.
module smfp_step (
	input  logic               [7:0] byte_in,
	input  logic                     start_of_file,
	input  smfp_pkg::pstate_t        cur,
	output smfp_pkg::pstate_t        nxt,
	output logic                     emit,
	output smfp_pkg::rec_t           rec
);

	always_comb begin
		smfp_pkg::pstate_t s;
		smfp_pkg::rec_t    r;
		logic              e;
		logic [31:0]       vlq;
		logic [7:0]        hi;
		logic [39:0]       seq;
		logic [31:0]       rem_n;

		s = cur;
		if (start_of_file) begin
			s = '0;
			s.phase = smfp_pkg::PH_HDR;
		end
		r = '0;
		r.track_number = s.trk_idx;
		r.timestamp = s.tick;
		e = 1'b0;
		vlq = {s.len_acc[24:0], byte_in[6:0]};
		hi = {s.cur_st[7:4], 4'h0};
		seq = '0;
		rem_n = '0;

		if (!s.halted) begin
			case (s.phase)
				smfp_pkg::PH_HDR: begin
					if (s.idx < 4'd4 && byte_in != smfp_pkg::hdr_id(s.idx[1:0])) begin
						e = 1'b1;
						r.kind = smfp_pkg::K_BAD_HEADER;
						r.track_number = '0;
						r.timestamp = '0;
						s.halted = 1'b1;
					end else begin
						if (s.idx == 4'd8 || s.idx == 4'd9)
							s.fmt = {s.fmt[7:0], byte_in};
						else if (s.idx == 4'd10 || s.idx == 4'd11)
							s.trk_tot = {s.trk_tot[7:0], byte_in};
						else if (s.idx >= 4'd12)
							s.shift = {24'd0, s.shift[7:0], byte_in};
						if (s.idx < 4'd13) begin
							s.idx = s.idx + 4'd1;
						end else begin
							s.idx = '0;
							e = 1'b1;
							r.track_number = '0;
							r.timestamp = '0;
							r.data_a = s.fmt;
							r.data_b = s.trk_tot;
							r.packed_payload = s.shift;
							s.shift = '0;
							if (s.fmt == 16'd0 && s.trk_tot != 16'd1) begin
								r.kind = smfp_pkg::K_BAD_HEADER;
								s.halted = 1'b1;
							end else begin
								r.kind = smfp_pkg::K_HEADER;
								if (s.trk_tot == 16'd0) begin
									r.file_done = 1'b1;
									s.halted = 1'b1;
								end else begin
									s.phase = smfp_pkg::PH_TRK;
								end
							end
						end
					end
				end
				smfp_pkg::PH_TRK: begin
					if (s.idx[2:0] < 3'd4 &&
						byte_in != smfp_pkg::trk_id(s.idx[1:0])) begin
						e = 1'b1;
						r.kind = smfp_pkg::K_BAD_TRACK;
						r.track_number = s.trk_idx + 16'd1;
						r.timestamp = '0;
						s.halted = 1'b1;
					end else if (s.idx[2:0] < 3'd7) begin
						s.idx = {1'b0, s.idx[2:0] + 3'd1};
					end else begin
						s.idx = '0;
						s.len_acc = '0;
						s.trk_idx = s.trk_idx + 16'd1;
						s.tick = '0;
						s.run_st = '0;
						s.phase = smfp_pkg::PH_DELTA;
						e = 1'b1;
						r.kind = smfp_pkg::K_TRACK;
						r.track_number = s.trk_idx;
						r.timestamp = '0;
					end
				end
				smfp_pkg::PH_DELTA: begin
					if (byte_in[7]) begin
						s.len_acc = vlq;
					end else begin
						s.tick = s.tick + vlq;
						s.len_acc = '0;
						s.phase = smfp_pkg::PH_STATUS;
					end
				end
				smfp_pkg::PH_STATUS: begin
					if (!byte_in[7]) begin
						if (s.run_st == 8'd0) begin
							e = 1'b1;
							r.kind = smfp_pkg::K_BAD_STATUS;
							r.data_a = {8'd0, byte_in};
							s.phase = smfp_pkg::PH_DELTA;
						end else begin
							s.cur_st = s.run_st;
							if (s.run_st[7:5] == 3'b110) begin
								e = 1'b1;
								r.kind = smfp_pkg::K_CHANNEL;
								r.status_byte = s.run_st;
								r.data_a = {8'd0, byte_in};
								s.phase = smfp_pkg::PH_DELTA;
							end else begin
								s.shift = {32'd0, byte_in};
								s.phase = smfp_pkg::PH_DATA2;
							end
						end
					end else if (byte_in[7:4] != 4'hF) begin
						s.cur_st = byte_in;
						s.run_st = byte_in;
						s.phase = smfp_pkg::PH_DATA1;
					end else begin
						s.run_st = '0;
						s.len_acc = '0;
						if (byte_in == smfp_pkg::ST_SYSEX || byte_in == smfp_pkg::ST_ESCAPE) begin
							s.cur_st = byte_in;
							s.meta_t = '0;
							s.phase = smfp_pkg::PH_SYXLEN;
						end else if (byte_in == smfp_pkg::ST_META) begin
							s.cur_st = smfp_pkg::ST_META;
							s.phase = smfp_pkg::PH_MTYPE;
						end else begin
							s.phase = smfp_pkg::PH_DELTA;
						end
					end
				end
				smfp_pkg::PH_DATA1: begin
					if (s.cur_st[7:5] == 3'b110) begin
						e = 1'b1;
						r.kind = smfp_pkg::K_CHANNEL;
						r.status_byte = s.cur_st;
						r.data_a = {8'd0, byte_in};
						s.phase = smfp_pkg::PH_DELTA;
					end else begin
						s.shift = {32'd0, byte_in};
						s.phase = smfp_pkg::PH_DATA2;
					end
				end
				smfp_pkg::PH_DATA2: begin
					e = 1'b1;
					r.kind = smfp_pkg::K_CHANNEL;
					r.status_byte = s.cur_st;
					if (hi == 8'hE0) begin
						r.data_a = {2'b00, byte_in[6:0], s.shift[6:0]};
					end else begin
						r.data_a = {8'd0, s.shift[7:0]};
						r.data_b = {8'd0, byte_in};
					end
					s.phase = smfp_pkg::PH_DELTA;
				end
				smfp_pkg::PH_SYXLEN: begin
					if (byte_in[7]) begin
						s.len_acc = vlq;
					end else begin
						s.len_acc = '0;
						s.remain = vlq;
						e = 1'b1;
						r.kind = smfp_pkg::K_SYSEX;
						r.status_byte = s.cur_st;
						r.payload_length = vlq;
						s.phase = (vlq != 32'd0) ? smfp_pkg::PH_RUN : smfp_pkg::PH_DELTA;
					end
				end
				smfp_pkg::PH_MTYPE: begin
					s.meta_t = byte_in;
					s.len_acc = '0;
					s.phase = smfp_pkg::PH_MLEN;
				end
				smfp_pkg::PH_MLEN: begin
					s.len_acc = vlq;
					if (!byte_in[7]) begin
						if (s.meta_t == smfp_pkg::META_EOT) begin
							s.len_acc = '0;
							e = 1'b1;
							r.kind = smfp_pkg::K_END_TRACK;
							r.status_byte = smfp_pkg::ST_META;
							r.meta_type = smfp_pkg::META_EOT;
							if (s.trk_idx >= s.trk_tot) begin
								r.file_done = 1'b1;
								s.halted = 1'b1;
							end else begin
								s.phase = smfp_pkg::PH_TRK;
								s.idx = '0;
							end
						end else if (smfp_pkg::is_fixed_meta(s.meta_t)) begin
							s.remain = vlq;
							s.shift = '0;
							s.idx = '0;
							if (vlq == 32'd0) begin
								e = 1'b1;
								r.kind = smfp_pkg::K_FIXED_META;
								r.status_byte = smfp_pkg::ST_META;
								r.meta_type = s.meta_t;
								s.len_acc = '0;
								s.phase = smfp_pkg::PH_DELTA;
							end else begin
								s.phase = smfp_pkg::PH_FIXED;
							end
						end else begin
							s.len_acc = '0;
							s.remain = vlq;
							e = 1'b1;
							r.kind = smfp_pkg::K_RUN_META;
							r.status_byte = smfp_pkg::ST_META;
							r.meta_type = s.meta_t;
							r.payload_length = vlq;
							s.phase = (vlq != 32'd0) ? smfp_pkg::PH_RUN : smfp_pkg::PH_DELTA;
						end
					end
				end
				smfp_pkg::PH_FIXED: begin
					if (s.idx < 4'd5) begin
						s.shift = {s.shift[31:0], byte_in};
						s.idx = s.idx + 4'd1;
					end
					rem_n = (s.remain != 32'd0) ? s.remain - 32'd1 : s.remain;
					s.remain = rem_n;
					if (rem_n == 32'd0) begin
						// Sequence number takes the first two bytes received.
						case (s.idx)
							4'd3:    seq = {8'd0, s.shift[39:8]};
							4'd4:    seq = {16'd0, s.shift[39:16]};
							4'd5:    seq = {24'd0, s.shift[39:24]};
							default: seq = s.shift;
						endcase
						e = 1'b1;
						r.kind = smfp_pkg::K_FIXED_META;
						r.status_byte = smfp_pkg::ST_META;
						r.meta_type = s.meta_t;
						r.data_a = (s.meta_t == smfp_pkg::META_SEQ) ? seq[15:0] : 16'd0;
						r.packed_payload = s.shift;
						r.payload_length = s.len_acc;
						s.len_acc = '0;
						s.phase = smfp_pkg::PH_DELTA;
					end
				end
				smfp_pkg::PH_RUN: begin
					e = 1'b1;
					r.kind = smfp_pkg::K_PAYLOAD;
					r.status_byte = s.cur_st;
					r.meta_type = s.meta_t;
					r.data_a = {8'd0, byte_in};
					if (s.remain <= 32'd1) begin
						r.last_in_run = 1'b1;
						s.remain = '0;
						s.phase = smfp_pkg::PH_DELTA;
					end else begin
						s.remain = s.remain - 32'd1;
					end
				end
				default: begin
					s.phase = smfp_pkg::PH_DELTA;
				end
			endcase
		end
		nxt = s;
		emit = e;
		rec = r;
	end

endmodule

/* rtl/core/midi_file_event_parser.sv */
// Top level of the byte-serial Standard MIDI File event parser.
//
//  channel | direction | handshake       | payload
//  input   | in        | in_valid/stall  | byte_in, start_of_file
//  output  | out       | out_valid/stall | kind .. file_done
//
// One byte is taken per cycle while in_stall is low. An accepted byte is held
// in an input register; when it advances, the step logic updates the parser
// state and, where the byte completes a record, loads the result register.
// The input register frees whenever the result register is empty or is being
// taken, so a stall on the output side holds back at most the two bytes in
// flight. Reset clears the valid flags and the parser state; start_of_file
// also restarts the parser in band.
module midi_file_event_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [15:0] track_number,
	output logic [31:0] timestamp,
	output logic [7:0]  status_byte,
	output logic [7:0]  meta_type,
	output logic [15:0] data_a,
	output logic [15:0] data_b,
	output logic [39:0] packed_payload,
	output logic [31:0] payload_length,
	output logic        last_in_run,
	output logic        file_done
);

	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              sof_s1;
	smfp_pkg::pstate_t state_q;
	smfp_pkg::pstate_t state_nxt;
	logic              emit;
	smfp_pkg::rec_t    rec_nxt;
	smfp_pkg::rec_t    rec_s2;
	logic              vld_s2;
	logic              adv;

	// The held byte advances when the result slot is free or being drained.
	assign adv = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
			sof_s1  <= start_of_file;
		end
	end

	smfp_step u_step (
		.byte_in       (byte_s1),
		.start_of_file (sof_s1),
		.cur           (state_q),
		.nxt           (state_nxt),
		.emit          (emit),
		.rec           (rec_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: smfp_pkg::PH_HDR, default: '0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= emit;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rec_s2 <= rec_nxt;
		end
	end

	assign out_valid      = vld_s2;
	assign kind           = rec_s2.kind;
	assign track_number   = rec_s2.track_number;
	assign timestamp      = rec_s2.timestamp;
	assign status_byte    = rec_s2.status_byte;
	assign meta_type      = rec_s2.meta_type;
	assign data_a         = rec_s2.data_a;
	assign data_b         = rec_s2.data_b;
	assign packed_payload = rec_s2.packed_payload;
	assign payload_length = rec_s2.payload_length;
	assign last_in_run    = rec_s2.last_in_run;
	assign file_done      = rec_s2.file_done;

	// A pending record is never overwritten while it is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !adv)
		else $error("record overwritten under stall");

	// Parser state only changes when a byte is consumed.
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv) |-> $stable(state_q))
		else $error("parser state moved without a byte");

	// Header records always carry track number zero.
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == smfp_pkg::K_HEADER || kind == smfp_pkg::K_BAD_HEADER)
		|-> track_number == 16'd0)
		else $error("header record with track number");

endmodule
